>>> hdl/stk_pkg.sv
// shared constants and types for the stochastic %k block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package stk_pkg;

    localparam int MAX_WINDOW    = 64;
    localparam int PRICE_BITS    = 32;
    localparam int LEN_BITS      = 7;
    localparam int CNT_BITS      = $clog2(MAX_WINDOW + 1);
    localparam int STEP_BITS     = $clog2(MAX_WINDOW);
    localparam int K_BITS        = 15;
    localparam int DIFF_BITS     = PRICE_BITS + 1;
    localparam int PROD_BITS     = PRICE_BITS + K_BITS;
    localparam int DIV_CNT_BITS  = $clog2(K_BITS);

    localparam int IN_DATA_BITS  = ((3 * PRICE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((K_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 2;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [K_BITS-1:0]          FULL_SCALE        = K_BITS'(25600);
    localparam logic [LEN_BITS-1:0]        RESET_WINDOW      = LEN_BITS'(14);
    localparam logic [APB_ADDR_BITS-3:0]   REG_WINDOW_LENGTH = '0;

    // divider status seen by the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

>>> hdl/stk_cell.sv
// one cell of the bar history ring: holds the high and low of one bar
// depends on stk_pkg
`timescale 1ns / 1ps
`default_nettype none

module stk_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [stk_pkg::PRICE_BITS-1:0]  i_high,
    input  wire logic [stk_pkg::PRICE_BITS-1:0]  i_low,
    output logic      [stk_pkg::PRICE_BITS-1:0]  o_high,
    output logic      [stk_pkg::PRICE_BITS-1:0]  o_low
);
    import stk_pkg::*;

    logic [PRICE_BITS-1:0] r_high;
    logic [PRICE_BITS-1:0] r_low;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_high <= i_high;
            r_low  <= i_low;
        end
    end

    assign o_high = r_high;
    assign o_low  = r_low;

endmodule

`default_nettype wire

>>> hdl/stk_div.sv
// scaling multiply and restoring divider: floor(num * 25600 / den), num < den
// depends on stk_pkg
`timescale 1ns / 1ps
`default_nettype none

module stk_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [stk_pkg::PRICE_BITS-1:0]  i_num,
    input  wire logic [stk_pkg::PRICE_BITS-1:0]  i_den,
    output logic      [stk_pkg::K_BITS-1:0]      o_quo,
    output stk_pkg::t_div_stat                   o_stat
);
    import stk_pkg::*;

    logic                    r_load;
    logic                    r_busy;
    logic                    r_done;
    logic [PROD_BITS-1:0]    r_prod;
    logic [PRICE_BITS-1:0]   r_den;
    logic [PRICE_BITS-1:0]   r_rem;
    logic [K_BITS-1:0]       r_low;
    logic [DIV_CNT_BITS-1:0] r_cnt;

    logic [PROD_BITS-1:0]    w_prod;
    logic [PRICE_BITS:0]     w_trial;
    logic [PRICE_BITS:0]     w_diff;
    logic                    w_ge;
    logic                    w_last;

    assign w_prod  = {{K_BITS{1'b0}}, i_num} * {{PRICE_BITS{1'b0}}, FULL_SCALE};
    assign w_trial = {r_rem, r_low[K_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_last  = (r_cnt == DIV_CNT_BITS'(K_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_load <= 1'b1;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_load) begin
            r_load <= 1'b0;
        end else if (r_busy && w_last) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    // product top half is below den, so it seeds the remainder directly
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= w_prod;
            r_den  <= i_den;
        end else if (r_load) begin
            r_rem <= r_prod[PROD_BITS-1:K_BITS];
            r_low <= r_prod[K_BITS-1:0];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[PRICE_BITS-1:0] : w_trial[PRICE_BITS-1:0];
            r_low <= {r_low[K_BITS-2:0], w_ge};
            r_cnt <= r_cnt + DIV_CNT_BITS'(1);
        end
    end

    assign o_quo       = r_low;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

>>> hdl/stochastic_percent_k.sv
// raw stochastic %k: one result per bar, history kept in a ring of 64 cells
// a new bar is taken only in idle, once the previous result has moved to the output
// register; each bar then goes through the 64-step rotation of the cell ring for the
// high/low scan, the difference, normalise and compare states, and the 15-step divider
// when the quotient is divided out, not when the result clamps or the range is flat
// reset (synchronous, active low) clears control and bar count, window length back to 14
`timescale 1ns / 1ps
`default_nettype none

module stochastic_percent_k (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // bar_high, bar_low, bar_close from bit 0 up
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [stk_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // percent_k from bit 0, zero padded
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [stk_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // window_full, flat_range from bit 0 up
    output logic      [stk_pkg::OUT_USER_BITS-1:0]  m_axis_tuser,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [stk_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [stk_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [stk_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready
);
    import stk_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_DIFF = 7'b0000100,
        S_NORM = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [LEN_BITS-1:0]     r_window_length;
    logic [CNT_BITS-1:0]     r_bars_seen;
    logic [CNT_BITS-1:0]     r_count;
    logic                    r_full;
    logic [STEP_BITS-1:0]    r_step;
    logic [PRICE_BITS-1:0]   r_close;
    logic [PRICE_BITS-1:0]   r_hi;
    logic [PRICE_BITS-1:0]   r_lo;
    logic [DIFF_BITS-1:0]    r_num;
    logic [DIFF_BITS-1:0]    r_den_s;
    logic [PRICE_BITS-1:0]   r_den;
    logic                    r_flat;
    logic [K_BITS-1:0]       r_k;
    logic                    r_out_valid;
    logic [K_BITS-1:0]       r_out_k;
    logic                    r_out_full;
    logic                    r_out_flat;

    logic [PRICE_BITS-1:0]   w_chain_high [MAX_WINDOW+1];
    logic [PRICE_BITS-1:0]   w_chain_low  [MAX_WINDOW+1];
    logic                    w_accept;
    logic                    w_shift;
    logic                    w_out_take;
    logic [CNT_BITS-1:0]     n_bars_seen;
    logic [CNT_BITS-1:0]     w_len;
    logic [STEP_BITS-1:0]    w_age;
    logic                    w_in_win;
    logic [PRICE_BITS-1:0]   w_tail_high;
    logic [PRICE_BITS-1:0]   w_tail_low;
    logic                    w_num_le0;
    logic                    w_divide;
    logic [DIFF_BITS-1:0]    w_den_neg;
    logic                    w_div_start;
    logic [K_BITS-1:0]       w_quo;
    t_div_stat               w_div_stat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_shift       = w_accept || (r_state == S_SCAN);
    assign w_out_take    = !r_out_valid || m_axis_tready;

    // ring of cells: a new bar enters at the head, during the scan the tail feeds back
    assign w_chain_high[0] = (r_state == S_IDLE) ? s_axis_tdata[PRICE_BITS-1:0]
                                                 : w_chain_high[MAX_WINDOW];
    assign w_chain_low[0]  = (r_state == S_IDLE) ? s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS]
                                                 : w_chain_low[MAX_WINDOW];

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        stk_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_shift),
            .i_high (w_chain_high[g]),
            .i_low  (w_chain_low[g]),
            .o_high (w_chain_high[g+1]),
            .o_low  (w_chain_low[g+1])
        );
    end

    assign w_tail_high = w_chain_high[MAX_WINDOW];
    assign w_tail_low  = w_chain_low[MAX_WINDOW];

    always_comb begin
        if (r_window_length == '0) begin
            w_len = CNT_BITS'(1);
        end else if (int'(r_window_length) > MAX_WINDOW) begin
            w_len = CNT_BITS'(MAX_WINDOW);
        end else begin
            w_len = CNT_BITS'(r_window_length);
        end
    end

    assign n_bars_seen = (r_bars_seen < CNT_BITS'(MAX_WINDOW)) ?
                         r_bars_seen + CNT_BITS'(1) : r_bars_seen;

    // the tail cell holds the oldest bar first, the newest on the last step
    assign w_age    = STEP_BITS'(MAX_WINDOW - 1) - r_step;
    assign w_in_win = (CNT_BITS'(w_age) < r_count);

    assign w_den_neg   = -r_den_s;
    assign w_num_le0   = r_num[DIFF_BITS-1] || (r_num == '0);
    assign w_divide    = !r_flat && !w_num_le0 && (r_num[PRICE_BITS-1:0] < r_den);
    assign w_div_start = (r_state == S_CMP) && w_divide;

    stk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num[PRICE_BITS-1:0]),
        .i_den   (r_den),
        .o_quo   (w_quo),
        .o_stat  (w_div_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_step == STEP_BITS'(MAX_WINDOW - 1)) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_state = S_NORM;
            end
            S_NORM: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = w_divide ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_window_length <= RESET_WINDOW;
            r_bars_seen     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready &&
                paddr[APB_ADDR_BITS-1:2] == REG_WINDOW_LENGTH) begin
                r_window_length <= pwdata[LEN_BITS-1:0];
            end
            if (w_accept) begin
                r_bars_seen <= n_bars_seen;
            end
            if ((r_state == S_DONE) && w_out_take) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_close <= s_axis_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
            r_count <= (n_bars_seen < w_len) ? n_bars_seen : w_len;
            r_full  <= (n_bars_seen >= w_len);
            r_hi    <= '0;
            r_lo    <= '1;
            r_step  <= '0;
        end
        if (r_state == S_SCAN) begin
            r_step <= r_step + STEP_BITS'(1);
            if (w_in_win && (w_tail_high > r_hi)) begin
                r_hi <= w_tail_high;
            end
            if (w_in_win && (w_tail_low < r_lo)) begin
                r_lo <= w_tail_low;
            end
        end
        if (r_state == S_DIFF) begin
            r_num   <= {1'b0, r_close} - {1'b0, r_lo};
            r_den_s <= {1'b0, r_hi} - {1'b0, r_lo};
            r_flat  <= (r_hi == r_lo);
        end
        // inverted range: negate both differences
        if (r_state == S_NORM) begin
            if (r_den_s[DIFF_BITS-1]) begin
                r_num <= -r_num;
                r_den <= w_den_neg[PRICE_BITS-1:0];
            end else begin
                r_den <= r_den_s[PRICE_BITS-1:0];
            end
        end
        if (r_state == S_CMP) begin
            r_k <= (r_flat || w_num_le0) ? '0 : FULL_SCALE;
        end
        if ((r_state == S_DIV) && w_div_stat.done) begin
            r_k <= w_quo;
        end
        if ((r_state == S_DONE) && w_out_take) begin
            r_out_k    <= r_k;
            r_out_full <= r_full;
            r_out_flat <= r_flat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_BITS - K_BITS){1'b0}}, r_out_k};
    assign m_axis_tuser  = {r_out_flat, r_out_full};

    assign pready = 1'b1;
    assign prdata = (psel && paddr[APB_ADDR_BITS-1:2] == REG_WINDOW_LENGTH) ?
                    APB_DATA_BITS'(r_window_length) : '0;

endmodule

`default_nettype wire

>>> hdl/stk_checker.sv
// port-level checks for stochastic_percent_k, attached by bind
// depends on stk_pkg and the top level's port list
`timescale 1ns / 1ps
`default_nettype none

module stk_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [stk_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input wire logic [stk_pkg::OUT_USER_BITS-1:0]  m_axis_tuser
);
    import stk_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[K_BITS-1:0] <= FULL_SCALE)
        else $error("percent_k above full scale");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[K_BITS-1:0] == '0)
        else $error("flat range with nonzero percent_k");

    a_one_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second bar taken during scan");

endmodule

bind stochastic_percent_k stk_checker u_stk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
